FILE: src/sdt_pkg.sv
package sdt_pkg;

   localparam int unsigned PAL_ENTRIES = 256;
   localparam int unsigned PAL_AW      = 8;
   localparam int unsigned CSR_IW      = 2;
   localparam int unsigned CSR_DW      = 11;
   localparam int unsigned DIM_W       = 11;
   localparam int unsigned COORD_W     = 10;
   localparam int unsigned ADDR_W      = 22;

   typedef enum logic [1:0] {
      OP_WR_PAL = 2'd0,
      OP_WR_TEX = 2'd1,
      OP_RD     = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH   = 2'd0,
      CSR_HEIGHT  = 2'd1,
      CSR_SWIZZLE = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_ADDR,
      ST_FETCH,
      ST_LOOK
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] store_address;
      logic [31:0] write_value;
      logic [9:0]  pixel_x;
      logic [9:0]  pixel_y;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       out_of_range;
   } rsp_type;

   function automatic logic [PAL_AW-1:0] stripe_swap(input logic [7:0] idx);
      return {idx[7:5], idx[3], idx[4], idx[2:0]};
   endfunction

endpackage

FILE: src/swizzled_8bpp_texture_decoder.sv
// a read beat steps through CALC, ADDR, FETCH and LOOK, result strobe shown in LOOK
// no new beat is taken during a read; palette or texture writes one per cycle while idle
// CALC does the width multiply, ADDR the address check with texture read, FETCH the palette read
// results are shown for one cycle only, the receiver cannot stall them
// synchronous reset returns control and config registers to defaults, memories kept
module swizzled_8bpp_texture_decoder #(
   parameter int unsigned TEXTURE_BYTES = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  sdt_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   output sdt_pkg::rsp_type             rsp_payload,
   input  logic                         csr_write,
   input  logic [sdt_pkg::CSR_IW-1:0]   csr_index,
   input  logic [sdt_pkg::CSR_DW-1:0]   csr_wdata
);

   localparam int unsigned TEX_AW = (TEXTURE_BYTES > 1) ? $clog2(TEXTURE_BYTES) : 1;
   localparam logic [sdt_pkg::ADDR_W-1:0] TEX_LIMIT = sdt_pkg::ADDR_W'(TEXTURE_BYTES);

   logic [7:0]  tex_mem [TEXTURE_BYTES];
   logic [31:0] pal_mem [sdt_pkg::PAL_ENTRIES];

   sdt_pkg::state_type state_ff, state_in;

   logic [sdt_pkg::DIM_W-1:0] width_ff, height_ff;
   logic                      swizzle_ff;

   logic [sdt_pkg::COORD_W-1:0] x_ff, y_ff;
   logic [20:0]                 prod_ff;
   logic [10:0]                 offs_ff;
   logic                        bounds_ff;
   logic                        bad_ff;
   logic [7:0]                  tex_rd_ff;
   logic [31:0]                 pal_rd_ff;

   logic                        accept;
   logic [sdt_pkg::ADDR_W-1:0]  wr_addr;
   logic [sdt_pkg::ADDR_W-1:0]  taddr;
   logic                        taddr_bad;
   logic [9:0]                  mult_m;
   logic [10:0]                 offs;
   logic                        swap;
   logic [2:0]                  col;

   assign accept  = start && !busy;
   assign wr_addr = sdt_pkg::ADDR_W'(req_payload.store_address);

   // address split into one multiply by width and an added offset, block swizzled or linear
   always_comb begin
      swap = y_ff[2] ^ y_ff[1];
      col  = {x_ff[2] ^ swap, x_ff[1:0]};
      if (swizzle_ff) begin
         mult_m = {y_ff[9:4], y_ff[3], y_ff[2], y_ff[0], 1'b0};
         offs   = {x_ff[9:4], col, x_ff[3], y_ff[1]};
      end else begin
         mult_m = y_ff;
         offs   = {1'b0, x_ff};
      end
   end

   assign taddr     = sdt_pkg::ADDR_W'(prod_ff) + sdt_pkg::ADDR_W'(offs_ff);
   assign taddr_bad = (taddr >= TEX_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= sdt_pkg::DIM_W'(256);
         height_ff  <= sdt_pkg::DIM_W'(256);
         swizzle_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            sdt_pkg::CSR_WIDTH:   width_ff   <= csr_wdata;
            sdt_pkg::CSR_HEIGHT:  height_ff  <= csr_wdata;
            sdt_pkg::CSR_SWIZZLE: swizzle_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdt_pkg::ST_IDLE: begin
            if (accept && req_payload.operation == sdt_pkg::OP_RD) begin
               state_in = sdt_pkg::ST_CALC;
            end
         end
         sdt_pkg::ST_CALC:  state_in = sdt_pkg::ST_ADDR;
         sdt_pkg::ST_ADDR:  state_in = sdt_pkg::ST_FETCH;
         sdt_pkg::ST_FETCH: state_in = sdt_pkg::ST_LOOK;
         sdt_pkg::ST_LOOK:  state_in = sdt_pkg::ST_IDLE;
         default:           state_in = sdt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      rsp_payload = '0;
      case (state_ff)
         sdt_pkg::ST_IDLE: busy = 1'b0;
         sdt_pkg::ST_LOOK: begin
            rsp_valid = 1'b1;
            rsp_payload.out_of_range = bad_ff;
            if (!bad_ff) begin
               rsp_payload.red   = pal_rd_ff[7:0];
               rsp_payload.green = pal_rd_ff[15:8];
               rsp_payload.blue  = pal_rd_ff[23:16];
               rsp_payload.alpha = pal_rd_ff[31:24];
            end
         end
         default: busy = 1'b1;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_payload.pixel_x;
         y_ff <= req_payload.pixel_y;
      end
      if (state_ff == sdt_pkg::ST_CALC) begin
         prod_ff   <= 21'(width_ff) * 21'(mult_m);
         offs_ff   <= offs;
         bounds_ff <= ({1'b0, x_ff} >= width_ff) || ({1'b0, y_ff} >= height_ff);
      end
      if (state_ff == sdt_pkg::ST_ADDR) begin
         bad_ff <= bounds_ff || taddr_bad;
      end
   end

   // texture memory
   always_ff @(posedge clock) begin
      if (accept && req_payload.operation == sdt_pkg::OP_WR_TEX && wr_addr < TEX_LIMIT) begin
         tex_mem[wr_addr[TEX_AW-1:0]] <= req_payload.write_value[7:0];
      end
      if (state_ff == sdt_pkg::ST_ADDR && !bounds_ff && !taddr_bad) begin
         tex_rd_ff <= tex_mem[taddr[TEX_AW-1:0]];
      end
   end

   // palette memory
   always_ff @(posedge clock) begin
      if (accept && req_payload.operation == sdt_pkg::OP_WR_PAL &&
          req_payload.store_address[15:8] == 8'd0) begin
         pal_mem[req_payload.store_address[7:0]] <= req_payload.write_value;
      end
      if (state_ff == sdt_pkg::ST_FETCH && !bad_ff) begin
         pal_rd_ff <= pal_mem[sdt_pkg::stripe_swap(tex_rd_ff)];
      end
   end

endmodule

FILE: src/sdt_checker.sv
module sdt_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input sdt_pkg::req_type req_payload,
   input logic             rsp_valid,
   input sdt_pkg::rsp_type rsp_payload
);

   logic rd_beat;
   assign rd_beat = start && !busy && req_payload.operation == sdt_pkg::OP_RD;

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_rd_latency: assert property (@(posedge clock) disable iff (reset)
      rd_beat |-> ##4 rsp_valid)
      else $error("read result not on time");

   a_rsp_then_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("not free after result");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_of_range |->
         rsp_payload.red == 8'd0 && rsp_payload.green == 8'd0 &&
         rsp_payload.blue == 8'd0 && rsp_payload.alpha == 8'd0)
      else $error("out of range colour not zero");

endmodule

bind swizzled_8bpp_texture_decoder sdt_checker u_sdt_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

FILE: verif/tb_swizzled_8bpp_texture_decoder.sv
`timescale 1ns / 100ps

module tb_swizzled_8bpp_texture_decoder;

   localparam int unsigned TEX_BYTES    = 65536;
   localparam int unsigned READ_LATENCY = 4;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        start       = 1'b0;
   logic                        busy;
   sdt_pkg::req_type            req_payload = '0;
   logic                        rsp_valid;
   sdt_pkg::rsp_type            rsp_payload;
   logic                        csr_write   = 1'b0;
   logic [sdt_pkg::CSR_IW-1:0]  csr_index   = '0;
   logic [sdt_pkg::CSR_DW-1:0]  csr_wdata   = '0;

   // mirror of the block
   logic [7:0]   texel_mem     [0:TEX_BYTES-1];
   bit           texel_written [0:TEX_BYTES-1];
   logic [31:0]  clut_mem      [0:sdt_pkg::PAL_ENTRIES-1];
   bit           clut_written  [0:sdt_pkg::PAL_ENTRIES-1];
   int unsigned  img_width   = 256;
   int unsigned  img_height  = 256;
   bit           img_swizzle = 1'b1;

   sdt_pkg::rsp_type pending_pixels [$];
   int unsigned      pixel_errors = 0;
   bit               sender_gaps  = 1'b1;

   swizzled_8bpp_texture_decoder #(
      .TEXTURE_BYTES(TEX_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("swizzled_8bpp_texture_decoder test failed");
      $finish;
   end

   function automatic int unsigned block_swizzle_addr(int unsigned x, int unsigned y,
                                                      int unsigned w);
      int unsigned base;
      int unsigned shift;
      int unsigned row;
      int unsigned col;
      int unsigned sel;
      base  = (y & ~32'hF) * w + (x & ~32'hF) * 2;
      shift = ((y + 2) >> 2) & 1;
      row   = (((y & ~32'h3) >> 1) + (y & 1)) & 7;
      col   = row * w * 2 + ((x + shift * 4) & 7) * 4;
      sel   = ((y >> 1) & 1) + ((x >> 2) & 2);
      return base + col + sel;
   endfunction

   function automatic logic [7:0] palette_stripe(logic [7:0] idx);
      logic [7:0] res;
      res    = idx;
      res[3] = idx[4];
      res[4] = idx[3];
      return res;
   endfunction

   // 1 when the pixel is inside the image and its byte inside the store
   function automatic bit fetch_address(int unsigned x, int unsigned y,
                                        output int unsigned addr);
      addr = 0;
      if (x >= img_width || y >= img_height) return 1'b0;
      addr = img_swizzle ? block_swizzle_addr(x, y, img_width) : y * img_width + x;
      return addr < TEX_BYTES;
   endfunction

   function automatic void decode_beat(sdt_pkg::req_type b);
      sdt_pkg::rsp_type px;
      int unsigned      addr;
      logic [31:0]      rgba;
      case (b.operation)
         sdt_pkg::OP_WR_PAL: begin
            if (b.store_address < sdt_pkg::PAL_ENTRIES) begin
               clut_mem[b.store_address[7:0]]     = b.write_value;
               clut_written[b.store_address[7:0]] = 1'b1;
            end
         end
         sdt_pkg::OP_WR_TEX: begin
            if (b.store_address < TEX_BYTES) begin
               texel_mem[b.store_address]     = b.write_value[7:0];
               texel_written[b.store_address] = 1'b1;
            end
         end
         sdt_pkg::OP_RD: begin
            px = '0;
            if (fetch_address(32'(b.pixel_x), 32'(b.pixel_y), addr)) begin
               rgba     = clut_mem[palette_stripe(texel_mem[addr])];
               px.red   = rgba[7:0];
               px.green = rgba[15:8];
               px.blue  = rgba[23:16];
               px.alpha = rgba[31:24];
            end else begin
               px.out_of_range = 1'b1;
            end
            pending_pixels.push_back(px);
         end
         default: ;
      endcase
   endfunction

   function automatic void note_mismatch(string what, sdt_pkg::rsp_type want,
                                         sdt_pkg::rsp_type got);
      pixel_errors++;
      if (pixel_errors <= 10)
         $display("%t %s: expected r=%h g=%h b=%h a=%h oor=%b, got r=%h g=%h b=%h a=%h oor=%b",
                  $realtime, what, want.red, want.green, want.blue, want.alpha,
                  want.out_of_range, got.red, got.green, got.blue, got.alpha,
                  got.out_of_range);
   endfunction

   always @(posedge clock) begin
      sdt_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            note_mismatch("result with nothing pending", '0, rsp_payload);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_payload.red !== want.red || rsp_payload.green !== want.green ||
                rsp_payload.blue !== want.blue || rsp_payload.alpha !== want.alpha ||
                rsp_payload.out_of_range !== want.out_of_range)
               note_mismatch("pixel mismatch", want, rsp_payload);
         end
      end
   end

   function automatic sdt_pkg::req_type noise_beat();
      sdt_pkg::req_type b;
      b.operation     = 2'($urandom_range(0, 3));
      b.store_address = 16'($urandom);
      b.write_value   = $urandom;
      b.pixel_x       = 10'($urandom);
      b.pixel_y       = 10'($urandom);
      return b;
   endfunction

   function automatic sdt_pkg::req_type write_beat(logic [1:0] op, int unsigned addr,
                                                   logic [31:0] value);
      sdt_pkg::req_type b;
      b               = noise_beat();
      b.operation     = op;
      b.store_address = addr[15:0];
      b.write_value   = value;
      return b;
   endfunction

   task automatic send_beat(sdt_pkg::req_type b);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (busy);
      decode_beat(b);
   endtask

   // any texel or palette entry the read touches is written first unless already written
   task automatic read_pixel(int unsigned x, int unsigned y);
      sdt_pkg::req_type b;
      int unsigned      addr;
      logic [7:0]       idx;
      if (fetch_address(x, y, addr)) begin
         if (!texel_written[addr]) send_beat(write_beat(sdt_pkg::OP_WR_TEX, addr, $urandom));
         idx = palette_stripe(texel_mem[addr]);
         if (!clut_written[idx]) send_beat(write_beat(sdt_pkg::OP_WR_PAL, 32'(idx), $urandom));
      end
      b           = noise_beat();
      b.operation = sdt_pkg::OP_RD;
      b.pixel_x   = x[9:0];
      b.pixel_y   = y[9:0];
      send_beat(b);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (READ_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(sdt_pkg::csr_type idx, logic [sdt_pkg::CSR_DW-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_image(int unsigned w, int unsigned h, bit swz);
      drain_results();
      write_reg(sdt_pkg::CSR_WIDTH, w[sdt_pkg::CSR_DW-1:0]);
      write_reg(sdt_pkg::CSR_HEIGHT, h[sdt_pkg::CSR_DW-1:0]);
      write_reg(sdt_pkg::CSR_SWIZZLE, {{(sdt_pkg::CSR_DW-1){1'b0}}, swz});
      csr_write   <= 1'b0;
      img_width   = w;
      img_height  = h;
      img_swizzle = swz;
   endtask

   task automatic random_traffic(int unsigned count);
      int unsigned pick;
      int unsigned addr;
      for (int unsigned n = 0; n < count; n++) begin
         // hold off once per phase until the pipeline is empty
         if (n == count / 2) drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 9) == 0)
               read_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            else
               read_pixel($urandom_range(0, img_width - 1), $urandom_range(0, img_height - 1));
         end else if (pick < 65) begin
            addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, sdt_pkg::PAL_ENTRIES - 1);
            send_beat(write_beat(sdt_pkg::OP_WR_PAL, addr, $urandom));
         end else if (pick < 95) begin
            if ($urandom_range(0, 1) == 0 ||
                !fetch_address($urandom_range(0, img_width - 1),
                               $urandom_range(0, img_height - 1), addr))
               addr = $urandom_range(0, 65535);
            send_beat(write_beat(sdt_pkg::OP_WR_TEX, addr, $urandom));
         end else begin
            send_beat(write_beat(OP_UNUSED, $urandom, $urandom));
         end
      end
   endtask

   task automatic test_directed_cases();
      send_beat(write_beat(sdt_pkg::OP_WR_PAL, 0, 32'hFFFF_FFFF));
      send_beat(write_beat(sdt_pkg::OP_WR_PAL, sdt_pkg::PAL_ENTRIES - 1, 32'h0000_0000));
      send_beat(write_beat(sdt_pkg::OP_WR_PAL, sdt_pkg::PAL_ENTRIES, 32'h1234_5678));
      send_beat(write_beat(sdt_pkg::OP_WR_PAL, 32'hFFFF, 32'h8765_4321));
      send_beat(write_beat(sdt_pkg::OP_WR_TEX, 0, 32'h0000_00FF));
      send_beat(write_beat(sdt_pkg::OP_WR_TEX, TEX_BYTES - 1, 32'hFFFF_FF00));
      send_beat(write_beat(sdt_pkg::OP_WR_TEX, 32'h1234, 32'h0000_0018));
      read_pixel(0, 0);
      read_pixel(255, 255);
      read_pixel(255, 0);
      read_pixel(0, 255);
      read_pixel(17, 3);
      read_pixel(256, 0);
      read_pixel(0, 256);
      read_pixel(1023, 1023);
      send_beat(write_beat(OP_UNUSED, 0, 32'hFFFF_FFFF));
      read_pixel(6, 2);
   endtask

   task automatic test_image_bounds();
      program_image(0, 256, 1'b1);
      read_pixel(0, 0);
      read_pixel(5, 5);
      program_image(256, 0, 1'b0);
      read_pixel(0, 0);
      program_image(1, 1, 1'b1);
      read_pixel(0, 0);
      read_pixel(1, 0);
      read_pixel(0, 1);
      program_image(1, 1, 1'b0);
      read_pixel(0, 0);
      program_image(1024, 1024, 1'b1);
      read_pixel(1023, 0);
      read_pixel(0, 63);
      read_pixel(0, 64);
      read_pixel(1023, 1023);
      program_image(1024, 1024, 1'b0);
      read_pixel(1023, 63);
      read_pixel(0, 64);
      read_pixel(0, 1023);
   endtask

   task automatic test_swizzled_traffic();
      program_image(256, 256, 1'b1);
      random_traffic(280);
      program_image(32, 16, 1'b1);
      random_traffic(150);
   endtask

   task automatic test_linear_traffic();
      program_image(48, 40, 1'b0);
      random_traffic(150);
      program_image(256, 256, 1'b0);
      random_traffic(120);
   endtask

   task automatic test_large_image_traffic();
      program_image(1024, 1024, 1'b1);
      random_traffic(120);
      program_image(1024, 1024, 1'b0);
      random_traffic(100);
   endtask

   task automatic test_random_geometry();
      repeat (4)
         begin
            program_image($urandom_range(1, 1024), $urandom_range(1, 1024),
                          1'($urandom_range(0, 1)));
            random_traffic(30);
         end
   endtask

   task automatic test_back_to_back();
      sender_gaps = 1'b0;
      program_image(64, 64, 1'b1);
      random_traffic(130);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_image_bounds();
      test_swizzled_traffic();
      test_linear_traffic();
      test_large_image_traffic();
      test_random_geometry();
      test_back_to_back();
      drain_results();
      if (pixel_errors == 0) begin
         $display("swizzled_8bpp_texture_decoder test passed");
      end else begin
         $display("swizzled_8bpp_texture_decoder test failed");
      end
      $finish;
   end

endmodule
